/* rtl/core/ita_pkg.sv */
// Shared types, codes and constants for the integer to ASCII formatter.
// No dependencies; used by rtl/core/integer_to_ascii_formatter.sv.
package ita_pkg;

  // Default width of the formatted value.
  localparam int unsigned VALUE_BITS_DEFAULT = 32;

  // Format selector codes.
  localparam logic [1:0] OP_BIN  = 2'd0;
  localparam logic [1:0] OP_DEC  = 2'd1;
  localparam logic [1:0] OP_HEX  = 2'd2;
  localparam logic [1:0] OP_SWAP = 2'd3;

  // ASCII characters used in a line.
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_A       = 8'h61;
  localparam logic [7:0] CHAR_B       = 8'h62;
  localparam logic [7:0] CHAR_X       = 8'h78;
  localparam logic [7:0] CHAR_MINUS   = 8'h2d;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0a;

  // Reciprocal of ten: (v * RECIP_TEN) >> RECIP_SHIFT is v / 10 for any 32-bit v.
  localparam logic [31:0] RECIP_TEN   = 32'hcccc_cccd;
  localparam int unsigned RECIP_SHIFT = 35;

  // Mask of one byte, used by the byte swap.
  localparam logic [31:0] BYTE_MASK = 32'h0000_00ff;

  // Input transaction payload.
  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  op;
    logic        negative;
  } item_t;

  // Output transaction payload.
  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
  } text_t;

  // Reverse the four bytes of a 32-bit word.
  function automatic logic [31:0] swap_bytes(input logic [31:0] v);
    logic [31:0] b0;
    logic [31:0] b1;
    logic [31:0] b2;
    logic [31:0] b3;
    b0 = v & BYTE_MASK;
    b1 = (v >> 8) & BYTE_MASK;
    b2 = (v >> 16) & BYTE_MASK;
    b3 = (v >> 24) & BYTE_MASK;
    return (b0 << 24) | (b1 << 16) | (b2 << 8) | b3;
  endfunction

  // ASCII character of one digit, lowercase for ten and above.
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    if (d < 4'd10) begin
      return CHAR_ZERO + {4'b0000, d};
    end
    return CHAR_A + {4'b0000, d} - 8'd10;
  endfunction

endpackage

/* rtl/core/integer_to_ascii_formatter.sv */
// Integer to ASCII formatter: one value in, one text line out, one character per transaction.
// Depends on rtl/core/ita_pkg.sv.

// The block takes one value at a time and is not ready until the line of the previous
// value has been handed to the output register. Digits come out of one shared unit,
// least significant first, into a small digit memory: binary and hex get each digit in
// ST_DIGIT (shift and mask), decimal passes through ST_MULT (a registered 32 by 32
// multiply by the reciprocal of ten) and then ST_DIGIT (the remainder fix-up). A setup
// state, ST_PREP, follows, then the line streams at one character per cycle while the
// consumer keeps ready high, and after the newline the block returns to idle, where the
// next value is accepted. A decimal line with D digits holds D + 1 characters (D + 2
// with a minus sign); a full-width binary line holds 35. A consumer that holds ready
// low stalls the line. Leading zeros are suppressed, a zero value prints one '0', and
// the closing newline carries the last flag.
module integer_to_ascii_formatter #(
  parameter int unsigned VALUE_BITS = ita_pkg::VALUE_BITS_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_ready,
  input  ita_pkg::item_t item,
  output logic           text_valid,
  input  logic           text_ready,
  output ita_pkg::text_t text
);

  localparam int unsigned WORK_BITS = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam int unsigned ADDR_W    = $clog2(VALUE_BITS);
  localparam int unsigned CNT_W     = $clog2(VALUE_BITS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULT,
    ST_DIGIT,
    ST_PREP,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    PH_PRE0,
    PH_PRE1,
    PH_DIGIT,
    PH_NEWLINE
  } phase_t;

  // Registers.
  state_t                 state;
  phase_t                 phase;
  logic [WORK_BITS-1:0]   work_value;
  logic [63:0]            prod;
  logic [1:0]             fmt;
  logic                   neg;
  logic [CNT_W-1:0]       digit_count;
  logic [ADDR_W-1:0]      ptr;
  logic [3:0]             rd_q;
  ita_pkg::text_t         text_q;
  logic                   text_valid_q;

  // Next values.
  state_t                 state_next;
  phase_t                 phase_next;
  logic [WORK_BITS-1:0]   work_value_next;
  logic [1:0]             fmt_next;
  logic                   neg_next;
  logic [CNT_W-1:0]       digit_count_next;
  logic [ADDR_W-1:0]      ptr_next;
  ita_pkg::text_t         text_next;
  logic                   text_valid_next;

  // Digit unit and memory port signals.
  logic [31:0]            src_value;
  logic [31:0]            work32;
  logic [31:0]            quo32;
  logic [31:0]            dec_rem;
  logic [WORK_BITS-1:0]   quo;
  logic [3:0]             rem;
  logic [CNT_W-1:0]       count_plus;
  logic                   wr_en;
  logic                   load_en;
  logic                   is_prefixed;

  // Digit memory, least significant digit at index zero.
  logic [3:0] digit_store [VALUE_BITS];

  assign item_ready = (state == ST_IDLE);
  assign text_valid = text_valid_q;
  assign text       = text_q;

  // Shared digit unit: shift and mask for binary and hex, reciprocal fix-up for decimal.
  assign src_value  = (item.op == ita_pkg::OP_SWAP) ? ita_pkg::swap_bytes(item.value)
                                                    : item.value;
  assign work32     = 32'(work_value);
  assign quo32      = 32'(prod >> ita_pkg::RECIP_SHIFT);
  assign dec_rem    = work32 - (quo32 << 3) - (quo32 << 1);
  assign count_plus = digit_count + CNT_W'(1);
  assign load_en    = !text_valid_q || text_ready;
  assign is_prefixed = (fmt == ita_pkg::OP_BIN) || (fmt == ita_pkg::OP_HEX) ||
                       ((fmt == ita_pkg::OP_DEC) && neg);

  always_comb begin
    case (fmt)
      ita_pkg::OP_BIN: begin
        quo = work_value >> 1;
        rem = {3'b000, work_value[0]};
      end
      ita_pkg::OP_HEX: begin
        quo = work_value >> 4;
        rem = work_value[3:0];
      end
      default: begin
        quo = WORK_BITS'(quo32);
        rem = dec_rem[3:0];
      end
    endcase
  end

  // Sequencer: extraction, setup, then character output.
  always_comb begin
    state_next       = state;
    phase_next       = phase;
    work_value_next  = work_value;
    fmt_next         = fmt;
    neg_next         = neg;
    digit_count_next = digit_count;
    ptr_next         = ptr;
    text_next        = text_q;
    text_valid_next  = text_valid_q && !text_ready;
    wr_en            = 1'b0;

    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          work_value_next  = src_value[WORK_BITS-1:0];
          fmt_next         = item.op;
          neg_next         = item.negative;
          digit_count_next = '0;
          if ((item.op == ita_pkg::OP_DEC) || (item.op == ita_pkg::OP_SWAP)) begin
            state_next = ST_MULT;
          end else begin
            state_next = ST_DIGIT;
          end
        end
      end
      ST_MULT: begin
        state_next = ST_DIGIT;
      end
      ST_DIGIT: begin
        wr_en            = 1'b1;
        work_value_next  = quo;
        digit_count_next = count_plus;
        if ((quo == '0) || (count_plus == CNT_W'(VALUE_BITS))) begin
          state_next = ST_PREP;
        end else if ((fmt == ita_pkg::OP_DEC) || (fmt == ita_pkg::OP_SWAP)) begin
          state_next = ST_MULT;
        end
      end
      ST_PREP: begin
        ptr_next   = ADDR_W'(digit_count - CNT_W'(1));
        phase_next = is_prefixed ? PH_PRE0 : PH_DIGIT;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (load_en) begin
          text_valid_next = 1'b1;
          text_next.last  = 1'b0;
          case (phase)
            PH_PRE0: begin
              if (fmt == ita_pkg::OP_DEC) begin
                text_next.out_char = ita_pkg::CHAR_MINUS;
                phase_next         = PH_DIGIT;
              end else begin
                text_next.out_char = ita_pkg::CHAR_ZERO;
                phase_next         = PH_PRE1;
              end
            end
            PH_PRE1: begin
              text_next.out_char = (fmt == ita_pkg::OP_BIN) ? ita_pkg::CHAR_B
                                                            : ita_pkg::CHAR_X;
              phase_next         = PH_DIGIT;
            end
            PH_DIGIT: begin
              text_next.out_char = ita_pkg::digit_char(rd_q);
              if (ptr == '0) begin
                phase_next = PH_NEWLINE;
              end else begin
                ptr_next = ptr - ADDR_W'(1);
              end
            end
            default: begin
              text_next.out_char = ita_pkg::CHAR_NEWLINE;
              text_next.last     = 1'b1;
              state_next         = ST_IDLE;
            end
          endcase
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      phase        <= PH_PRE0;
      work_value   <= '0;
      digit_count  <= '0;
      text_valid_q <= 1'b0;
    end else begin
      state        <= state_next;
      phase        <= phase_next;
      work_value   <= work_value_next;
      digit_count  <= digit_count_next;
      text_valid_q <= text_valid_next;
    end
    prod   <= 64'(work32) * 64'(ita_pkg::RECIP_TEN);
    fmt    <= fmt_next;
    neg    <= neg_next;
    ptr    <= ptr_next;
    text_q <= text_next;
  end

  // Digit memory: one write port during extraction, registered read of the next pointer.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      digit_store[digit_count[ADDR_W-1:0]] <= rem;
    end
    rd_q <= digit_store[ptr_next];
  end

endmodule
